// ===== hdl/rfig_pkg.sv =====
// Shared types, constants and functions of the RTTY FSK IQ generator.
// Holds the ITA2 code tables, state machine types and the interfaces between blocks.
// No dependencies.
package rfig_pkg;

    localparam int ENTRY_W     = 21;
    localparam int LEN_W       = 20;
    localparam int STAGE_DEPTH = 24;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SPB        = 3'd0;
    localparam logic [2:0] CFG_RAMP_LEN   = 3'd1;
    localparam logic [2:0] CFG_RAMP_SCALE = 3'd2;
    localparam logic [2:0] CFG_PREAMBLE   = 3'd3;
    localparam logic [2:0] CFG_TAIL       = 3'd4;
    localparam logic [2:0] CFG_PHASE_STEP = 3'd5;

    // ITA2 control codes.
    localparam logic [4:0] CODE_FIGS = 5'h1B;
    localparam logic [4:0] CODE_LTRS = 5'h1F;
    localparam logic [4:0] CODE_SP   = 5'h04;
    localparam logic [4:0] CODE_LF   = 5'h02;

    localparam logic [7:0] ASC_NUL   = 8'd0;
    localparam logic [7:0] ASC_TAB   = 8'd9;
    localparam logic [7:0] ASC_LF    = 8'd10;
    localparam logic [7:0] ASC_SPACE = 8'd32;

    localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [31:0] POLY_C0  = 32'd172273;
    localparam logic [31:0] QUARTER  = 32'h4000_0000;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHR, ST_TRD, ST_TLOAD, ST_TUPD, ST_TSYN, ST_FIN
    } t_top_st;

    typedef enum logic [2:0] {
        FR_IDLE, FR_CODE, FR_BIT, FR_END1, FR_END2, FR_CHECK, FR_WRITE, FR_DONE
    } t_frm_st;

    typedef enum logic [3:0] {
        SY_IDLE, SY_PREP, SY_SQ, SY_POLY, SY_FIN, SY_ENV, SY_MAG, SY_AMP, SY_DONE
    } t_syn_st;

    typedef enum logic [1:0] {PASS_ENV, PASS_I, PASS_Q} t_pass;

    typedef struct packed {
        logic                en;
        logic [ENTRY_W-1:0]  data;
    } t_seg_wr;

    typedef struct packed {
        logic done;
        logic accepted;
    } t_frm_res;

    typedef struct packed {
        logic [1:0] n;
        logic [4:0] c0;
        logic [4:0] c1;
        logic       figs;
    } t_enc;

    function automatic logic [31:0] poly_coef(input logic [1:0] k);
        logic [31:0] c;
        begin
            unique case (k)
                2'd0: c = 32'd5026993;
                2'd1: c = 32'd85569306;
                2'd2: c = 32'd693598668;
                2'd3: c = 32'd1686629713;
            endcase
            return c;
        end
    endfunction

    // Returns {found, index} for the letters shift.
    function automatic logic [5:0] letter_lookup(input logic [7:0] c);
        logic [5:0] r;
        begin
            unique case (c)
                "E": r = {1'b1, 5'd1};   "A": r = {1'b1, 5'd3};
                "S": r = {1'b1, 5'd5};   "I": r = {1'b1, 5'd6};
                "U": r = {1'b1, 5'd7};   "D": r = {1'b1, 5'd9};
                "R": r = {1'b1, 5'd10};  "J": r = {1'b1, 5'd11};
                "N": r = {1'b1, 5'd12};  "F": r = {1'b1, 5'd13};
                "C": r = {1'b1, 5'd14};  "K": r = {1'b1, 5'd15};
                "T": r = {1'b1, 5'd16};  "Z": r = {1'b1, 5'd17};
                "L": r = {1'b1, 5'd18};  "W": r = {1'b1, 5'd19};
                "H": r = {1'b1, 5'd20};  "Y": r = {1'b1, 5'd21};
                "P": r = {1'b1, 5'd22};  "Q": r = {1'b1, 5'd23};
                "O": r = {1'b1, 5'd24};  "B": r = {1'b1, 5'd25};
                "G": r = {1'b1, 5'd26};  "M": r = {1'b1, 5'd28};
                "X": r = {1'b1, 5'd29};  "V": r = {1'b1, 5'd30};
                default: r = 6'd0;
            endcase
            return r;
        end
    endfunction

    // Returns {found, index} for the figures shift.
    function automatic logic [5:0] figure_lookup(input logic [7:0] c);
        logic [5:0] r;
        begin
            unique case (c)
                "3":   r = {1'b1, 5'd1};   "-":   r = {1'b1, 5'd3};
                "8":   r = {1'b1, 5'd6};   "7":   r = {1'b1, 5'd7};
                "$":   r = {1'b1, 5'd9};   "4":   r = {1'b1, 5'd10};
                8'h27: r = {1'b1, 5'd11};  ",":   r = {1'b1, 5'd12};
                "!":   r = {1'b1, 5'd13};  ":":   r = {1'b1, 5'd14};
                "(":   r = {1'b1, 5'd15};  "5":   r = {1'b1, 5'd16};
                8'h22: r = {1'b1, 5'd17};  ")":   r = {1'b1, 5'd18};
                "2":   r = {1'b1, 5'd19};  "#":   r = {1'b1, 5'd20};
                "6":   r = {1'b1, 5'd21};  "0":   r = {1'b1, 5'd22};
                "1":   r = {1'b1, 5'd23};  "9":   r = {1'b1, 5'd24};
                "?":   r = {1'b1, 5'd25};  "&":   r = {1'b1, 5'd26};
                ".":   r = {1'b1, 5'd28};  "/":   r = {1'b1, 5'd29};
                ";":   r = {1'b1, 5'd30};
                default: r = 6'd0;
            endcase
            return r;
        end
    endfunction

    // Maps one ASCII byte to up to two ITA2 codes against the current shift.
    function automatic t_enc ita2_encode(input logic [7:0] ch, input logic figs);
        t_enc       e;
        logic [7:0] c;
        logic [5:0] l;
        logic [5:0] f;
        begin
            c = ch;
            if (c >= 8'h61 && c <= 8'h7A) begin
                c = c - 8'd32;
            end
            if (c == ASC_TAB) begin
                c = ASC_SPACE;
            end
            l = letter_lookup(c);
            f = figure_lookup(c);
            e = '0;
            e.figs = figs;
            priority if (c == ASC_SPACE) begin
                e.n = 2'd1; e.c0 = CODE_SP; e.figs = 1'b0;
            end else if (c == ASC_LF) begin
                e.n = 2'd1; e.c0 = CODE_LF;
            end else if (c == ASC_NUL) begin
                e.n = 2'd0;
            end else if (l[5]) begin
                if (figs) begin
                    e.n = 2'd2; e.c0 = CODE_LTRS; e.c1 = l[4:0]; e.figs = 1'b0;
                end else begin
                    e.n = 2'd1; e.c0 = l[4:0];
                end
            end else if (f[5]) begin
                if (!figs) begin
                    e.n = 2'd2; e.c0 = CODE_FIGS; e.c1 = f[4:0]; e.figs = 1'b1;
                end else begin
                    e.n = 2'd1; e.c0 = f[4:0];
                end
            end else begin
                e.n = 2'd0;
            end
            return e;
        end
    endfunction

endpackage

// ===== hdl/rfig_seg_mem.sv =====
// Segment queue storage: one write port, one read port with registered data.
// Depends on rfig_pkg for the entry width.
module rfig_seg_mem #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(FIFO_DEPTH)-1:0]     i_waddr,
    input  logic [rfig_pkg::ENTRY_W-1:0]      i_wdata,
    input  logic                              i_re,
    input  logic [$clog2(FIFO_DEPTH)-1:0]     i_raddr,
    output logic [rfig_pkg::ENTRY_W-1:0]      o_rdata
);

    logic [rfig_pkg::ENTRY_W-1:0] r_mem [FIFO_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hdl/rfig_framer.sv =====
// Character framer: ITA2 encoding with shift tracking, run staging and queue writes.
// Depends on rfig_pkg; writes into the segment queue through a t_seg_wr port.
module rfig_framer #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [7:0]                         i_char,
    input  logic                               i_idle,
    input  logic                               i_flush,
    input  logic [28:0]                        i_spb,
    input  logic [19:0]                        i_preamble,
    input  logic [$clog2(FIFO_DEPTH+1)-1:0]    i_count,
    output rfig_pkg::t_seg_wr                  o_wr,
    output rfig_pkg::t_frm_res                 o_res
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    rfig_pkg::t_frm_st r_st, n_st;

    logic                         r_shift;
    logic                         r_figs_new;
    logic [15:0]                  r_frac;
    logic [15:0]                  r_sfrac;
    logic [4:0]                   r_codes [3];
    logic [1:0]                   r_nc;
    logic [1:0]                   r_ci;
    logic                         r_tone;
    logic [3:0]                   r_h;
    logic [2:0]                   r_b;
    logic [rfig_pkg::ENTRY_W-1:0] r_stage [rfig_pkg::STAGE_DEPTH];
    logic [4:0]                   r_sn;
    logic [4:0]                   r_wi;
    logic                         r_acc;

    rfig_pkg::t_enc enc;
    logic           figs0;
    logic           is_ws;
    logic           reject;
    logic [4:0]     cur_code;
    logic           bit_m;
    logic           e_do;
    logic           e_tone;
    logic [3:0]     e_h;
    logic [32:0]    prod;
    logic [32:0]    want;
    logic           last_code;
    logic [CW:0]    free_slots;
    logic           fits;

    assign figs0  = i_idle ? 1'b0 : r_shift;
    assign enc    = rfig_pkg::ita2_encode(i_char, figs0);
    assign is_ws  = (i_char == rfig_pkg::ASC_SPACE) || (i_char == rfig_pkg::ASC_TAB) ||
                    (i_char == rfig_pkg::ASC_LF);
    assign reject = (i_idle && is_ws) || (enc.n == 2'd0);

    assign cur_code  = r_codes[r_ci];
    assign bit_m     = cur_code[r_b];
    assign last_code = (r_ci == r_nc - 2'd1);

    assign free_slots = (CW + 1)'(FIFO_DEPTH) - {1'b0, i_count};
    assign fits       = free_slots >= (CW + 1)'(r_sn);

    // Run emission for the current framing step.
    always_comb begin
        e_do   = 1'b0;
        e_tone = r_tone;
        e_h    = r_h;
        unique case (r_st)
            rfig_pkg::FR_BIT: begin
                e_do = (bit_m != r_tone);
            end
            rfig_pkg::FR_END1: begin
                e_do = 1'b1;
                e_h  = r_tone ? (r_h + 4'd3) : r_h;
            end
            rfig_pkg::FR_END2: begin
                e_do   = 1'b1;
                e_tone = 1'b1;
                e_h    = 4'd3;
            end
            default: begin
                e_do = 1'b0;
            end
        endcase
    end

    // The fraction is carried in a staging copy and committed only when the
    // character is written to the queue.
    assign prod = {29'd0, e_h} * {4'd0, i_spb};
    assign want = {1'b0, prod[32:1]} + {17'd0, r_sfrac};

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            rfig_pkg::FR_IDLE: begin
                if (i_start) begin
                    n_st = reject ? rfig_pkg::FR_DONE : rfig_pkg::FR_CODE;
                end
            end
            rfig_pkg::FR_CODE: n_st = rfig_pkg::FR_BIT;
            rfig_pkg::FR_BIT: begin
                if (r_b == 3'd4) begin
                    n_st = rfig_pkg::FR_END1;
                end
            end
            rfig_pkg::FR_END1: begin
                if (!r_tone) begin
                    n_st = rfig_pkg::FR_END2;
                end else begin
                    n_st = last_code ? rfig_pkg::FR_CHECK : rfig_pkg::FR_CODE;
                end
            end
            rfig_pkg::FR_END2: n_st = last_code ? rfig_pkg::FR_CHECK : rfig_pkg::FR_CODE;
            rfig_pkg::FR_CHECK: n_st = fits ? rfig_pkg::FR_WRITE : rfig_pkg::FR_DONE;
            rfig_pkg::FR_WRITE: begin
                if (r_wi == r_sn - 5'd1) begin
                    n_st = rfig_pkg::FR_DONE;
                end
            end
            rfig_pkg::FR_DONE: n_st = rfig_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        o_wr.en       = (r_st == rfig_pkg::FR_WRITE);
        o_wr.data     = r_stage[r_wi];
        o_res.done     = (r_st == rfig_pkg::FR_DONE);
        o_res.accepted = r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= rfig_pkg::FR_IDLE;
            r_shift <= 1'b0;
            r_frac  <= 16'd0;
            r_acc   <= 1'b0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                rfig_pkg::FR_IDLE: begin
                    if (i_flush) begin
                        r_frac <= 16'd0;
                    end
                    if (i_start) begin
                        r_acc      <= 1'b0;
                        r_figs_new <= enc.figs;
                        r_ci       <= 2'd0;
                        r_wi       <= 5'd0;
                        r_sfrac    <= r_frac;
                        if (i_idle) begin
                            r_codes[0] <= rfig_pkg::CODE_LTRS;
                            r_codes[1] <= enc.c0;
                            r_codes[2] <= enc.c1;
                            r_nc       <= enc.n + 2'd1;
                        end else begin
                            r_codes[0] <= enc.c0;
                            r_codes[1] <= enc.c1;
                            r_codes[2] <= enc.c1;
                            r_nc       <= enc.n;
                        end
                        // A new transmission opens with a steady mark preamble.
                        if (i_idle && (i_preamble != 20'd0)) begin
                            r_stage[0] <= {1'b1, i_preamble};
                            r_sn       <= 5'd1;
                        end else begin
                            r_sn <= 5'd0;
                        end
                    end
                end
                rfig_pkg::FR_CODE: begin
                    r_tone <= 1'b0;
                    r_h    <= 4'd2;
                    r_b    <= 3'd0;
                end
                rfig_pkg::FR_BIT, rfig_pkg::FR_END1, rfig_pkg::FR_END2: begin
                    if (r_st == rfig_pkg::FR_BIT) begin
                        r_b <= r_b + 3'd1;
                        if (bit_m == r_tone) begin
                            r_h <= r_h + 4'd2;
                        end else begin
                            r_h    <= 4'd2;
                            r_tone <= bit_m;
                        end
                    end
                    if ((r_st == rfig_pkg::FR_END2) ||
                        ((r_st == rfig_pkg::FR_END1) && r_tone)) begin
                        r_ci <= r_ci + 2'd1;
                    end
                    if (e_do) begin
                        r_sfrac <= want[15:0];
                        // Runs that round to zero samples are not queued.
                        if ((want[32:16] != 17'd0) && (r_sn < 5'(rfig_pkg::STAGE_DEPTH))) begin
                            r_stage[r_sn] <= {e_tone, 3'd0, want[32:16]};
                            r_sn          <= r_sn + 5'd1;
                        end
                    end
                end
                rfig_pkg::FR_CHECK: begin
                    r_wi <= 5'd0;
                end
                rfig_pkg::FR_WRITE: begin
                    r_wi <= r_wi + 5'd1;
                    if (r_wi == r_sn - 5'd1) begin
                        r_acc   <= 1'b1;
                        r_shift <= r_figs_new;
                        r_frac  <= r_sfrac;
                    end
                end
                rfig_pkg::FR_DONE: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

endmodule

// ===== hdl/rfig_synth.sv =====
// Sample synthesizer: key envelope and carrier I/Q through one shared multiplier.
// Evaluates the odd quarter-wave polynomial step by step. Depends on rfig_pkg.
module rfig_synth #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [15:0]                    i_ramp_pos,
    input  logic [15:0]                    i_ramp_len,
    input  logic [15:0]                    i_ramp_scale,
    input  logic [31:0]                    i_phase,
    output logic                           o_done,
    output logic signed [SAMPLE_WIDTH-1:0] o_i_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_q_sample
);

    localparam int LOWB = 32 - SINE_TABLE_BITS;
    localparam logic [31:0] AMP = 32'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);

    rfig_pkg::t_syn_st r_st, n_st;
    rfig_pkg::t_pass   r_pass;

    logic [1:0]  r_k;
    logic [30:0] r_z;
    logic [30:0] r_z2;
    logic [31:0] r_r;
    logic [30:0] r_env;
    logic        r_neg;

    logic [31:0] ph;
    logic [30:0] zraw;
    logic [30:0] zph;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [31:0] psh;
    logic [16:0] f_env;
    logic [63:0] rnd;
    logic [33:0] v;
    logic [SAMPLE_WIDTH-1:0] vmag;
    logic [SAMPLE_WIDTH-1:0] smp;

    assign ph   = (r_pass == rfig_pkg::PASS_I) ? (i_phase + rfig_pkg::QUARTER) : i_phase;
    assign zraw = {1'b0, ph[29:LOWB], {LOWB{1'b0}}};
    assign zph  = ph[30] ? (rfig_pkg::ONE_Q30[30:0] - zraw) : zraw;

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (r_st)
            rfig_pkg::SY_PREP: begin
                mul_a = {16'd0, i_ramp_pos};
                mul_b = {16'd0, i_ramp_scale};
            end
            rfig_pkg::SY_SQ:   begin mul_a = {1'b0, r_z};  mul_b = {1'b0, r_z}; end
            rfig_pkg::SY_POLY: begin mul_a = {1'b0, r_z2}; mul_b = r_r; end
            rfig_pkg::SY_FIN:  begin mul_a = {1'b0, r_z};  mul_b = r_r; end
            rfig_pkg::SY_ENV:  begin mul_a = r_r;          mul_b = r_r; end
            rfig_pkg::SY_MAG:  begin mul_a = {1'b0, r_env}; mul_b = r_r; end
            rfig_pkg::SY_AMP:  begin mul_a = r_r;          mul_b = AMP; end
            default:           begin mul_a = 32'd0;        mul_b = 32'd0; end
        endcase
    end

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};
    assign psh  = prod[61:30];

    // Ramp fraction in Q16: full scale at or past the ramp end.
    assign f_env = (i_ramp_pos < i_ramp_len) ?
                   ((prod > 64'd65536) ? 17'h10000 : prod[16:0]) : 17'h10000;

    assign rnd  = prod + 64'h2000_0000;
    assign v    = rnd[63:30];
    assign vmag = (v > {2'b00, AMP}) ? AMP[SAMPLE_WIDTH-1:0] : v[SAMPLE_WIDTH-1:0];
    assign smp  = r_neg ? (~vmag + 1'b1) : vmag;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            rfig_pkg::SY_IDLE: begin
                if (i_start) begin
                    n_st = rfig_pkg::SY_PREP;
                end
            end
            rfig_pkg::SY_PREP: n_st = rfig_pkg::SY_SQ;
            rfig_pkg::SY_SQ:   n_st = rfig_pkg::SY_POLY;
            rfig_pkg::SY_POLY: begin
                if (r_k == 2'd3) begin
                    n_st = rfig_pkg::SY_FIN;
                end
            end
            rfig_pkg::SY_FIN: begin
                n_st = (r_pass == rfig_pkg::PASS_ENV) ? rfig_pkg::SY_ENV : rfig_pkg::SY_MAG;
            end
            rfig_pkg::SY_ENV: n_st = rfig_pkg::SY_PREP;
            rfig_pkg::SY_MAG: n_st = rfig_pkg::SY_AMP;
            rfig_pkg::SY_AMP: begin
                n_st = (r_pass == rfig_pkg::PASS_I) ? rfig_pkg::SY_PREP : rfig_pkg::SY_DONE;
            end
            rfig_pkg::SY_DONE: n_st = rfig_pkg::SY_IDLE;
            default: n_st = rfig_pkg::SY_IDLE;
        endcase
    end

    assign o_done = (r_st == rfig_pkg::SY_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= rfig_pkg::SY_IDLE;
            r_pass <= rfig_pkg::PASS_ENV;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                rfig_pkg::SY_IDLE: begin
                    r_pass <= rfig_pkg::PASS_ENV;
                end
                rfig_pkg::SY_PREP: begin
                    if (r_pass == rfig_pkg::PASS_ENV) begin
                        r_z   <= {f_env, 14'd0};
                        r_neg <= 1'b0;
                    end else begin
                        r_z   <= zph;
                        r_neg <= ph[31];
                    end
                end
                rfig_pkg::SY_SQ: begin
                    r_z2 <= psh[30:0];
                    r_r  <= rfig_pkg::POLY_C0;
                    r_k  <= 2'd0;
                end
                rfig_pkg::SY_POLY: begin
                    r_r <= rfig_pkg::poly_coef(r_k) - psh;
                    r_k <= r_k + 2'd1;
                end
                rfig_pkg::SY_FIN: begin
                    r_r <= (psh > rfig_pkg::ONE_Q30) ? rfig_pkg::ONE_Q30 : psh;
                end
                rfig_pkg::SY_ENV: begin
                    r_env  <= (i_ramp_pos == 16'd0) ? 31'd0 : psh[30:0];
                    r_pass <= rfig_pkg::PASS_I;
                end
                rfig_pkg::SY_MAG: begin
                    r_r <= psh;
                end
                rfig_pkg::SY_AMP: begin
                    if (r_pass == rfig_pkg::PASS_I) begin
                        o_i_sample <= smp;
                        r_pass     <= rfig_pkg::PASS_Q;
                    end else begin
                        o_q_sample <= smp;
                    end
                end
                default: begin
                    r_pass <= r_pass;
                end
            endcase
        end
    end

endmodule

// ===== hdl/rtty_fsk_iq_generator.sv =====
// Top level of the RTTY FSK IQ generator: item control, queue pointers, keying state.
// Instantiates rfig_seg_mem, rfig_framer and rfig_synth; depends on rfig_pkg.
//
// Input channel (i_in_valid / o_in_stall) carries one item per transaction: kind 0 queues a
// character, kind 1 produces one I/Q sample, kind 2 flushes the queue. Every item yields
// exactly one result transaction on the output channel (o_out_valid / i_out_stall).
// Items are handled one at a time; o_in_stall is high while an item is in work.
// A tick passes through a queue read state (plus a load state when a new segment is popped),
// a state update step and rfig_synth, where the shared 32x32 multiplier works out the
// envelope, then I and Q, each a degree-9 polynomial, and then goes into the output register.
// A character is framed one data bit per cycle for each ITA2 code, then its queued segments
// are written to the queue memory one per cycle; a skipped or unmappable character writes
// nothing and goes straight to its result.
// Flush and unknown kinds go from acceptance straight to the output state.
// The result sits in an output register; the next item is accepted while it waits. If the
// receiver stalls, the block finishes the next item and holds before its result.
// Configuration writes take effect at once and are expected only while the block is idle.
// Synchronous active-low reset empties the queue, clears keying, ramp and phase and loads
// the register defaults; the queue memory itself is not cleared.
module rtty_fsk_iq_generator #(
    parameter int FIFO_DEPTH      = 64,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_kind,
    input  logic [7:0]                     i_char_code,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_i_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_q_sample,
    output logic                           o_keyed,
    output logic                           o_char_accepted,
    output logic                           o_idle,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_index,
    input  logic [28:0]                    i_cfg_data
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    rfig_pkg::t_top_st r_st, n_st;

    logic [28:0] r_spb;
    logic [15:0] r_ramp_len;
    logic [15:0] r_ramp_scale;
    logic [19:0] r_preamble;
    logic [15:0] r_tail_len;
    logic [27:0] r_step;

    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] r_wr_ptr;
    logic [CW-1:0] r_count;
    logic          r_cur_tone;
    logic [19:0]   r_cur_rem;
    logic          r_seg_act;
    logic [15:0]   r_tail;
    logic [15:0]   r_ramp;
    logic [31:0]   r_phase;

    logic r_is_tick;
    logic r_keyed;
    logic r_acc;

    logic accept;
    logic idle_now;
    logic need_pop;
    logic target;
    logic tone;
    logic out_free;

    rfig_pkg::t_seg_wr             frm_wr;
    rfig_pkg::t_frm_res            frm_res;
    logic [rfig_pkg::ENTRY_W-1:0]  mem_rdata;
    logic                          syn_done;
    logic [SAMPLE_WIDTH-1:0]       syn_i;
    logic [SAMPLE_WIDTH-1:0]       syn_q;

    assign accept   = i_in_valid && (r_st == rfig_pkg::ST_IDLE);
    assign o_in_stall = (r_st != rfig_pkg::ST_IDLE);
    assign idle_now = (r_count == '0) && !r_seg_act && (r_tail == 16'd0) && (r_ramp == 16'd0);
    assign need_pop = !r_seg_act && (r_count != '0);
    assign target   = r_seg_act || (r_tail != 16'd0);
    assign tone     = r_seg_act ? r_cur_tone : 1'b1;
    assign out_free = !o_out_valid || !i_out_stall;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(FIFO_DEPTH - 1)) ? '0 : (p + 1'b1);
    endfunction

    rfig_seg_mem #(.FIFO_DEPTH(FIFO_DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (frm_wr.en),
        .i_waddr (r_wr_ptr),
        .i_wdata (frm_wr.data),
        .i_re    ((r_st == rfig_pkg::ST_TRD) && need_pop),
        .i_raddr (r_rd_ptr),
        .o_rdata (mem_rdata)
    );

    rfig_framer #(.FIFO_DEPTH(FIFO_DEPTH)) u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && (i_kind == rfig_pkg::KIND_CHAR)),
        .i_char     (i_char_code),
        .i_idle     (idle_now),
        .i_flush    (accept && (i_kind == rfig_pkg::KIND_FLUSH)),
        .i_spb      (r_spb),
        .i_preamble (r_preamble),
        .i_count    (r_count),
        .o_wr       (frm_wr),
        .o_res      (frm_res)
    );

    rfig_synth #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_synth (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_st == rfig_pkg::ST_TUPD),
        .i_ramp_pos   (r_ramp),
        .i_ramp_len   (r_ramp_len),
        .i_ramp_scale (r_ramp_scale),
        .i_phase      (r_phase),
        .o_done       (syn_done),
        .o_i_sample   (syn_i),
        .o_q_sample   (syn_q)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb        <= 29'd69212937;
            r_ramp_len   <= 16'd240;
            r_ramp_scale <= 16'd273;
            r_preamble   <= 20'd4800;
            r_tail_len   <= 16'd1056;
            r_step       <= 28'd7605671;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rfig_pkg::CFG_SPB:        r_spb        <= i_cfg_data;
                rfig_pkg::CFG_RAMP_LEN:   r_ramp_len   <= i_cfg_data[15:0];
                rfig_pkg::CFG_RAMP_SCALE: r_ramp_scale <= i_cfg_data[15:0];
                rfig_pkg::CFG_PREAMBLE:   r_preamble   <= i_cfg_data[19:0];
                rfig_pkg::CFG_TAIL:       r_tail_len   <= i_cfg_data[15:0];
                rfig_pkg::CFG_PHASE_STEP: r_step       <= i_cfg_data[27:0];
                default:                  r_spb        <= r_spb;
            endcase
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            rfig_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        rfig_pkg::KIND_CHAR:  n_st = rfig_pkg::ST_CHR;
                        rfig_pkg::KIND_TICK:  n_st = rfig_pkg::ST_TRD;
                        rfig_pkg::KIND_FLUSH: n_st = rfig_pkg::ST_FIN;
                        rfig_pkg::KIND_NONE:  n_st = rfig_pkg::ST_FIN;
                    endcase
                end
            end
            rfig_pkg::ST_CHR: begin
                if (frm_res.done) begin
                    n_st = rfig_pkg::ST_FIN;
                end
            end
            rfig_pkg::ST_TRD:   n_st = need_pop ? rfig_pkg::ST_TLOAD : rfig_pkg::ST_TUPD;
            rfig_pkg::ST_TLOAD: n_st = rfig_pkg::ST_TUPD;
            rfig_pkg::ST_TUPD:  n_st = rfig_pkg::ST_TSYN;
            rfig_pkg::ST_TSYN: begin
                if (syn_done) begin
                    n_st = rfig_pkg::ST_FIN;
                end
            end
            rfig_pkg::ST_FIN: begin
                if (out_free) begin
                    n_st = rfig_pkg::ST_IDLE;
                end
            end
            default: n_st = rfig_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= rfig_pkg::ST_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_cur_tone  <= 1'b0;
            r_cur_rem   <= 20'd0;
            r_seg_act   <= 1'b0;
            r_tail      <= 16'd0;
            r_ramp      <= 16'd0;
            r_phase     <= 32'd0;
            o_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;

            if (o_out_valid && !i_out_stall && (r_st != rfig_pkg::ST_FIN)) begin
                o_out_valid <= 1'b0;
            end

            if (frm_wr.en) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
                r_count  <= r_count + 1'b1;
            end

            unique case (r_st)
                rfig_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_is_tick <= (i_kind == rfig_pkg::KIND_TICK);
                        r_keyed   <= 1'b0;
                        r_acc     <= 1'b0;
                        if (i_kind == rfig_pkg::KIND_FLUSH) begin
                            r_rd_ptr  <= '0;
                            r_wr_ptr  <= '0;
                            r_count   <= '0;
                            r_seg_act <= 1'b0;
                            r_cur_rem <= 20'd0;
                            r_tail    <= 16'd0;
                        end
                    end
                end
                rfig_pkg::ST_CHR: begin
                    if (frm_res.done) begin
                        r_acc <= frm_res.accepted;
                    end
                end
                rfig_pkg::ST_TLOAD: begin
                    r_cur_tone <= mem_rdata[rfig_pkg::LEN_W];
                    r_cur_rem  <= mem_rdata[rfig_pkg::LEN_W-1:0];
                    r_rd_ptr   <= ptr_inc(r_rd_ptr);
                    r_count    <= r_count - 1'b1;
                    r_seg_act  <= 1'b1;
                    r_tail     <= 16'd0;
                end
                rfig_pkg::ST_TUPD: begin
                    r_keyed <= target;
                    if (!r_seg_act && (r_tail != 16'd0)) begin
                        r_tail <= r_tail - 16'd1;
                    end
                    // With hard keying the ramp jumps straight between off and on.
                    if (r_ramp_len == 16'd0) begin
                        r_ramp <= {15'd0, target};
                    end else if (target && (r_ramp < r_ramp_len)) begin
                        r_ramp <= r_ramp + 16'd1;
                    end else if (!target && (r_ramp != 16'd0)) begin
                        r_ramp <= r_ramp - 16'd1;
                    end
                    r_phase <= tone ? (r_phase + {4'd0, r_step}) : (r_phase - {4'd0, r_step});
                end
                rfig_pkg::ST_TSYN: begin
                    if (syn_done && r_seg_act) begin
                        if (r_cur_rem <= 20'd1) begin
                            r_cur_rem <= 20'd0;
                            r_seg_act <= 1'b0;
                            if (r_count == '0) begin
                                r_tail <= r_tail_len;
                            end
                        end else begin
                            r_cur_rem <= r_cur_rem - 20'd1;
                        end
                    end
                end
                rfig_pkg::ST_FIN: begin
                    if (out_free) begin
                        o_out_valid     <= 1'b1;
                        o_i_sample      <= r_is_tick ? syn_i : '0;
                        o_q_sample      <= r_is_tick ? syn_q : '0;
                        o_keyed         <= r_keyed;
                        o_char_accepted <= r_acc;
                        o_idle          <= idle_now;
                    end
                end
                default: begin
                    r_keyed <= r_keyed;
                end
            endcase
        end
    end

endmodule

// ===== bench/rfig_checker.sv =====
// Checker for the RTTY FSK IQ generator: watches both channels and the configuration port.
// Predicts every result from its own model of the queue, framing, keying and oscillator.
// Depends on rfig_pkg for item kinds, register indexes and ITA2 control codes.
module rfig_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_char_code,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic signed [15:0] i_i_sample,
    input  logic signed [15:0] i_q_sample,
    input  logic              i_keyed,
    input  logic              i_char_accepted,
    input  logic              i_idle,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [28:0]       i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = 64;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned FULL_AMP = 64'd32767;

    typedef struct {
        logic [15:0] i_s;
        logic [15:0] q_s;
        logic        keyed;
        logic        acc;
        logic        idl;
    } t_sample;

    t_sample sample_q[$];

    // Configuration copy.
    logic [28:0] spb;
    logic [15:0] ramp_len, ramp_scl, tail_len;
    logic [19:0] pre_len;
    logic [27:0] step;

    // Transmitter state.
    logic [20:0] seg_mem [QDEPTH];
    int          rd_ptr, wr_ptr, seg_cnt;
    logic        figs_shift, cur_tone, seg_on;
    logic [15:0] frac, tail_left, ramp_at;
    logic [19:0] cur_rem;
    logic [31:0] phase;

    // Segments of the character being framed.
    logic [20:0] stg [24];
    int          stg_n;
    logic [15:0] stg_frac;

    byte ltr_tab [32] = '{8'h00, "E", 8'h0A, "A", " ", "S", "I", "U", 8'h00, "D", "R", "J",
                          "N", "F", "C", "K", "T", "Z", "L", "W", "H", "Y", "P", "Q", "O",
                          "B", "G", 8'h00, "M", "X", "V", 8'h00};
    byte fig_tab [32] = '{8'h00, "3", 8'h0A, "-", " ", 8'h00, "8", "7", 8'h00, "$", "4",
                          8'h27, ",", "!", ":", "(", "5", 8'h22, ")", "2", "#", "6", "0",
                          "1", "9", "?", "&", 8'h00, ".", "/", ";", 8'h00};

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        begin
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
            o_fail_count++;
        end
    endtask

    function automatic bit tx_idle();
        return seg_cnt == 0 && !seg_on && tail_left == 0 && ramp_at == 0;
    endfunction

    function automatic void add_run(input logic tone, input int halves);
        longint unsigned want;
        longint unsigned len;
        begin
            want = ((longint'(halves) * spb) >> 1) + stg_frac;
            len = want >> 16;
            stg_frac = want[15:0];
            if (len != 0 && stg_n < 24) begin
                stg[stg_n] = {tone, len[19:0]};
                stg_n++;
            end
        end
    endfunction

    // Start bit, five data bits LSB first, 1.5-bit stop, merged into runs of one tone.
    function automatic void frame_code(input logic [4:0] code);
        int   halves;
        logic tone;
        begin
            halves = 2;
            tone = 1'b0;
            for (int b = 0; b < 5; b++) begin
                if (code[b] == tone) begin
                    halves += 2;
                end else begin
                    add_run(tone, halves);
                    halves = 2;
                    tone = code[b];
                end
            end
            if (tone) begin
                add_run(1'b1, halves + 3);
            end else begin
                add_run(1'b0, halves);
                add_run(1'b1, 3);
            end
        end
    endfunction

    function automatic int to_ita2(input logic [7:0] ch, inout logic fg,
                                   output logic [4:0] c0, output logic [4:0] c1);
        logic [7:0] c;
        begin
            c = ch;
            c0 = '0;
            c1 = '0;
            if (c >= "a" && c <= "z") c = c - 8'd32;
            if (c == rfig_pkg::ASC_TAB) c = rfig_pkg::ASC_SPACE;
            if (c == rfig_pkg::ASC_SPACE) begin
                c0 = rfig_pkg::CODE_SP;
                fg = 1'b0;
                return 1;
            end
            if (c == rfig_pkg::ASC_LF) begin
                c0 = rfig_pkg::CODE_LF;
                return 1;
            end
            if (c == rfig_pkg::ASC_NUL) return 0;
            for (int n = 0; n < 32; n++) begin
                if (ltr_tab[n] == c) begin
                    if (fg) begin
                        fg = 1'b0;
                        c0 = rfig_pkg::CODE_LTRS;
                        c1 = n[4:0];
                        return 2;
                    end
                    c0 = n[4:0];
                    return 1;
                end
            end
            for (int n = 0; n < 32; n++) begin
                if (fig_tab[n] == c) begin
                    if (!fg) begin
                        fg = 1'b1;
                        c0 = rfig_pkg::CODE_FIGS;
                        c1 = n[4:0];
                        return 2;
                    end
                    c0 = n[4:0];
                    return 1;
                end
            end
            return 0;
        end
    endfunction

    // The whole character is queued or nothing of it is.
    function automatic logic queue_char(input logic [7:0] ch);
        logic       fg;
        logic [4:0] c0, c1;
        int         nc;
        bit         from_idle;
        begin
            fg = figs_shift;
            from_idle = tx_idle();
            if (from_idle && (ch == rfig_pkg::ASC_SPACE || ch == rfig_pkg::ASC_TAB ||
                              ch == rfig_pkg::ASC_LF)) return 1'b0;
            stg_n = 0;
            stg_frac = frac;
            if (from_idle) begin
                fg = 1'b0;
                if (pre_len != 0) begin
                    stg[stg_n] = {1'b1, pre_len};
                    stg_n++;
                end
            end
            nc = to_ita2(ch, fg, c0, c1);
            if (nc == 0) return 1'b0;
            if (from_idle) frame_code(rfig_pkg::CODE_LTRS);
            frame_code(c0);
            if (nc == 2) frame_code(c1);
            if (QDEPTH - seg_cnt < stg_n) return 1'b0;
            for (int n = 0; n < stg_n; n++) begin
                seg_mem[wr_ptr] = stg[n];
                wr_ptr = (wr_ptr + 1) % QDEPTH;
                seg_cnt++;
            end
            frac = stg_frac;
            figs_shift = fg;
            return 1'b1;
        end
    endfunction

    // sin(pi/2 * z) for z in Q30, odd polynomial, clamped to one.
    function automatic longint unsigned qsin(input longint unsigned z);
        longint unsigned z2, r;
        begin
            z2 = (z * z) >> 30;
            r = 64'd172273;
            r = 64'd5026993 - ((z2 * r) >> 30);
            r = 64'd85569306 - ((z2 * r) >> 30);
            r = 64'd693598668 - ((z2 * r) >> 30);
            r = 64'd1686629713 - ((z2 * r) >> 30);
            r = (z * r) >> 30;
            return (r > Q30_ONE) ? Q30_ONE : r;
        end
    endfunction

    function automatic logic [15:0] osc_out(input longint unsigned env, input logic [31:0] ph);
        logic [9:0]      idx;
        longint unsigned z, s, mag, v;
        begin
            idx = ph[31:22];
            z = longint'(idx[7:0]) << 22;
            if (idx[8]) z = Q30_ONE - z;
            s = qsin(z);
            mag = (env * s) >> 30;
            v = (mag * FULL_AMP + (64'd1 << 29)) >> 30;
            if (v > FULL_AMP) v = FULL_AMP;
            return idx[9] ? 16'(-v) : v[15:0];
        end
    endfunction

    function automatic void next_sample(ref t_sample r);
        logic            target, tone;
        longint unsigned f, s, env;
        begin
            if (!seg_on && seg_cnt != 0) begin
                cur_tone = seg_mem[rd_ptr][20];
                cur_rem = seg_mem[rd_ptr][19:0];
                rd_ptr = (rd_ptr + 1) % QDEPTH;
                seg_cnt--;
                seg_on = 1'b1;
                tail_left = 0;
            end
            if (seg_on) begin
                target = 1'b1;
                tone = cur_tone;
            end else if (tail_left > 0) begin
                target = 1'b1;
                tone = 1'b1;
                tail_left--;
            end else begin
                target = 1'b0;
                tone = 1'b1;
            end
            if (ramp_len == 0) ramp_at = {15'd0, target};
            else if (target && ramp_at < ramp_len) ramp_at++;
            else if (!target && ramp_at > 0) ramp_at--;
            if (ramp_at == 0) begin
                env = 0;
            end else begin
                f = 65536;
                if (ramp_at < ramp_len) begin
                    f = longint'(ramp_at) * ramp_scl;
                    if (f > 65536) f = 65536;
                end
                s = qsin(f << 14);
                env = (s * s) >> 30;
            end
            phase = tone ? phase + step : phase - step;
            r.i_s = osc_out(env, phase + 32'h4000_0000);
            r.q_s = osc_out(env, phase);
            r.keyed = target;
            if (seg_on) begin
                if (cur_rem <= 1) begin
                    cur_rem = 0;
                    seg_on = 1'b0;
                    if (seg_cnt == 0) tail_left = tail_len;
                end else begin
                    cur_rem--;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_sample e;
        if (!i_rst_n) begin
            spb = 29'd69212937; ramp_len = 16'd240; ramp_scl = 16'd273;
            pre_len = 20'd4800; tail_len = 16'd1056; step = 28'd7605671;
            rd_ptr = 0; wr_ptr = 0; seg_cnt = 0;
            figs_shift = 0; frac = 0; cur_tone = 0; cur_rem = 0;
            seg_on = 0; tail_left = 0; ramp_at = 0; phase = 0;
            sample_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sample_q.size() == 0) begin
                    report("unexpected result transaction", 16'd0, 16'd0);
                end else begin
                    e = sample_q.pop_front();
                    if (i_i_sample !== e.i_s) report("i_sample", i_i_sample, e.i_s);
                    if (i_q_sample !== e.q_s) report("q_sample", i_q_sample, e.q_s);
                    if (i_keyed !== e.keyed) report("keyed", i_keyed, e.keyed);
                    if (i_char_accepted !== e.acc) report("char_accepted", i_char_accepted, e.acc);
                    if (i_idle !== e.idl) report("idle", i_idle, e.idl);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rfig_pkg::CFG_SPB:        spb = i_cfg_data;
                    rfig_pkg::CFG_RAMP_LEN:   ramp_len = i_cfg_data[15:0];
                    rfig_pkg::CFG_RAMP_SCALE: ramp_scl = i_cfg_data[15:0];
                    rfig_pkg::CFG_PREAMBLE:   pre_len = i_cfg_data[19:0];
                    rfig_pkg::CFG_TAIL:       tail_len = i_cfg_data[15:0];
                    rfig_pkg::CFG_PHASE_STEP: step = i_cfg_data[27:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                e = '{16'd0, 16'd0, 1'b0, 1'b0, 1'b0};
                case (i_kind)
                    rfig_pkg::KIND_CHAR: e.acc = queue_char(i_char_code);
                    rfig_pkg::KIND_TICK: next_sample(e);
                    rfig_pkg::KIND_FLUSH: begin
                        rd_ptr = 0; wr_ptr = 0; seg_cnt = 0;
                        seg_on = 0; cur_rem = 0; tail_left = 0; frac = 0;
                    end
                    default: ;
                endcase
                e.idl = tx_idle();
                sample_q.push_back(e);
            end
        end
        o_pending = sample_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the RTTY FSK IQ generator: clock, reset, stimulus and verdict.
// Drives items and register writes through several settings; rfig_checker does the checking.
// Depends on rfig_pkg, rtty_fsk_iq_generator and rfig_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_kind = rfig_pkg::KIND_NONE;
    logic [7:0]        i_char_code = 8'd0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic signed [15:0] o_i_sample, o_q_sample;
    logic              o_keyed, o_char_accepted, o_idle;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_index = rfig_pkg::CFG_SPB;
    logic [28:0]       i_cfg_data = '0;

    int  fail_count, pending;
    bit  no_gaps = 0;
    bit  hold_req = 0;

    string text_chars = "THE QUICK BROWN FOX 0123456789 -?:$!&#'(),./; jumps\"\n\t";

    rtty_fsk_iq_generator DUT (.*);

    rfig_checker u_check (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_kind, .i_char_code,
        .i_out_valid(o_out_valid), .i_out_stall, .i_i_sample(o_i_sample),
        .i_q_sample(o_q_sample), .i_keyed(o_keyed), .i_char_accepted(o_char_accepted),
        .i_idle(o_idle), .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_out_stall = 1'b1;
                repeat (400) @(negedge i_clk);
            end
            w = no_gaps ? 0 : $urandom_range(0, 12);
            if (w != 0) begin
                i_out_stall = 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            #1;
            while (!o_out_valid) begin
                @(negedge i_clk);
                #1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic [1:0] k, input logic [7:0] c);
        int g;
        begin
            g = no_gaps ? 0 : $urandom_range(0, 12);
            if (g != 0) begin
                i_in_valid = 1'b0;
                repeat (g) @(negedge i_clk);
            end
            i_in_valid = 1'b1;
            i_kind = k;
            i_char_code = c;
            #1;
            while (o_in_stall) begin
                @(negedge i_clk);
                #1;
            end
            @(negedge i_clk);
        end
    endtask

    task automatic drain();
        begin
            i_in_valid = 1'b0;
            while (pending != 0) @(negedge i_clk);
            repeat (60) @(negedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [28:0] val);
        begin
            i_cfg_we = 1'b1;
            i_cfg_index = idx;
            i_cfg_data = val;
            @(negedge i_clk);
            i_cfg_we = 1'b0;
        end
    endtask

    task automatic set_all(input logic [28:0] spb, input logic [15:0] rl,
                           input logic [15:0] rs, input logic [19:0] pre,
                           input logic [15:0] tl, input logic [27:0] st);
        begin
            drain();
            cfg_write(rfig_pkg::CFG_SPB, spb);
            cfg_write(rfig_pkg::CFG_RAMP_LEN, rl);
            cfg_write(rfig_pkg::CFG_RAMP_SCALE, rs);
            cfg_write(rfig_pkg::CFG_PREAMBLE, pre);
            cfg_write(rfig_pkg::CFG_TAIL, tl);
            cfg_write(rfig_pkg::CFG_PHASE_STEP, st);
        end
    endtask

    // Mostly text and ticks; some random bytes, flushes and unknown kinds.
    task automatic random_items(input int count, input int tick_pct);
        int r;
        logic [7:0] c;
        begin
            for (int n = 0; n < count; n++) begin
                if (n % 80 == 0) no_gaps = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < tick_pct) begin
                    send_item(rfig_pkg::KIND_TICK, 8'($urandom));
                end else if (r < 94) begin
                    if ($urandom_range(0, 4) == 0) c = 8'($urandom);
                    else c = text_chars[$urandom_range(0, text_chars.len() - 1)];
                    send_item(rfig_pkg::KIND_CHAR, c);
                end else if (r < 97) begin
                    send_item(rfig_pkg::KIND_FLUSH, 8'($urandom));
                end else begin
                    send_item(rfig_pkg::KIND_NONE, 8'($urandom));
                end
            end
            no_gaps = 0;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Short run under the reset settings.
        random_items(60, 60);

        // Fast settings so the queue drains and the tail and ramps show.
        set_all(29'(3 * 65536 + 4321), 16'd4, 16'd16384, 20'd5, 16'd6, 28'd7605671);
        send_item(rfig_pkg::KIND_CHAR, rfig_pkg::ASC_SPACE);
        send_item(rfig_pkg::KIND_CHAR, rfig_pkg::ASC_TAB);
        send_item(rfig_pkg::KIND_CHAR, rfig_pkg::ASC_LF);
        send_item(rfig_pkg::KIND_CHAR, rfig_pkg::ASC_NUL);
        send_item(rfig_pkg::KIND_CHAR, "a");
        send_item(rfig_pkg::KIND_CHAR, "3");
        send_item(rfig_pkg::KIND_CHAR, "A");
        send_item(rfig_pkg::KIND_CHAR, rfig_pkg::ASC_LF);
        send_item(rfig_pkg::KIND_CHAR, rfig_pkg::ASC_TAB);
        send_item(rfig_pkg::KIND_CHAR, 8'hFF);
        send_item(rfig_pkg::KIND_CHAR, 8'h80);
        send_item(rfig_pkg::KIND_CHAR, "~");
        send_item(rfig_pkg::KIND_NONE, 8'h55);
        repeat (6) send_item(rfig_pkg::KIND_TICK, 8'h00);
        send_item(rfig_pkg::KIND_FLUSH, 8'hAA);
        repeat (6) send_item(rfig_pkg::KIND_TICK, 8'hFF);
        random_items(150, 75);
        hold_req = 1;
        random_items(200, 75);

        // Minimum samples per bit, hard keying, no preamble or tail, largest step.
        set_all(29'd65536, 16'd0, 16'd0, 20'd0, 16'd0, 28'hFFFFFFF);
        random_items(300, 70);

        // Maximum of every register but the phase step, which is zero; the queue fills and drops characters.
        set_all(29'h1FFFFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 28'd0);
        random_items(250, 50);

        // Fractional bit length with a short ramp.
        set_all(29'(2 * 65536 + 12345), 16'd3, 16'd30000, 20'd2, 16'd1,
                28'($urandom));
        random_items(350, 80);

        // Middle settings.
        set_all(29'(5 * 65536 + 999), 16'd20, 16'd3277, 20'd9, 16'd7, 28'd7605671);
        random_items(300, 75);

        drain();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
